### rtl/core/cpu8lsc_pkg.sv
// Shared types, opcodes and decode codes for the 8-bit load/store/compare unit.
`timescale 1ns / 1ps
`default_nettype none

package cpu8lsc_pkg;

   // Operation selector carried in the request tuser
   localparam logic [1:0] OPER_EXEC = 2'd0;
   localparam logic [1:0] OPER_HWR  = 2'd1;
   localparam logic [1:0] OPER_HRD  = 2'd2;

   // Instruction classes
   localparam logic [3:0] CLS_NOP   = 4'd0;
   localparam logic [3:0] CLS_LOAD  = 4'd1;
   localparam logic [3:0] CLS_STORE = 4'd2;
   localparam logic [3:0] CLS_CMP   = 4'd3;
   localparam logic [3:0] CLS_DEC   = 4'd4;
   localparam logic [3:0] CLS_MOVE  = 4'd5;
   localparam logic [3:0] CLS_HWR   = 4'd6;
   localparam logic [3:0] CLS_HRD   = 4'd7;
   localparam logic [3:0] CLS_UNSUP = 4'd8;

   // Register selectors
   localparam logic [1:0] REG_A = 2'd0;
   localparam logic [1:0] REG_X = 2'd1;
   localparam logic [1:0] REG_Y = 2'd2;
   localparam logic [1:0] REG_S = 2'd3;

   // Addressing modes
   localparam logic [2:0] AM_NONE = 3'd0;
   localparam logic [2:0] AM_IMM  = 3'd1;
   localparam logic [2:0] AM_ZP   = 3'd2;
   localparam logic [2:0] AM_ZPX  = 3'd3;
   localparam logic [2:0] AM_ZPY  = 3'd4;
   localparam logic [2:0] AM_ABS  = 3'd5;
   localparam logic [2:0] AM_ABX  = 3'd6;
   localparam logic [2:0] AM_ABY  = 3'd7;

   // Flag bit positions
   localparam int FLAG_C = 0;
   localparam int FLAG_Z = 1;
   localparam int FLAG_N = 2;

   // Opcodes
   localparam logic [7:0] OPC_LDA_IMM = 8'hA9;
   localparam logic [7:0] OPC_LDA_ZP  = 8'hA5;
   localparam logic [7:0] OPC_LDA_ZPX = 8'hB5;
   localparam logic [7:0] OPC_LDA_ABS = 8'hAD;
   localparam logic [7:0] OPC_LDA_ABX = 8'hBD;
   localparam logic [7:0] OPC_LDA_ABY = 8'hB9;
   localparam logic [7:0] OPC_LDX_IMM = 8'hA2;
   localparam logic [7:0] OPC_LDX_ZP  = 8'hA6;
   localparam logic [7:0] OPC_LDX_ZPY = 8'hB6;
   localparam logic [7:0] OPC_LDX_ABS = 8'hAE;
   localparam logic [7:0] OPC_LDX_ABY = 8'hBE;
   localparam logic [7:0] OPC_LDY_IMM = 8'hA0;
   localparam logic [7:0] OPC_LDY_ZP  = 8'hA4;
   localparam logic [7:0] OPC_LDY_ZPX = 8'hB4;
   localparam logic [7:0] OPC_LDY_ABS = 8'hAC;
   localparam logic [7:0] OPC_LDY_ABX = 8'hBC;
   localparam logic [7:0] OPC_STA_ZP  = 8'h85;
   localparam logic [7:0] OPC_STA_ZPX = 8'h95;
   localparam logic [7:0] OPC_STA_ABS = 8'h8D;
   localparam logic [7:0] OPC_STA_ABX = 8'h9D;
   localparam logic [7:0] OPC_STA_ABY = 8'h99;
   localparam logic [7:0] OPC_STX_ZP  = 8'h86;
   localparam logic [7:0] OPC_STX_ZPY = 8'h96;
   localparam logic [7:0] OPC_STX_ABS = 8'h8E;
   localparam logic [7:0] OPC_STY_ZP  = 8'h84;
   localparam logic [7:0] OPC_STY_ZPX = 8'h94;
   localparam logic [7:0] OPC_STY_ABS = 8'h8C;
   localparam logic [7:0] OPC_CMP_IMM = 8'hC9;
   localparam logic [7:0] OPC_CMP_ZP  = 8'hC5;
   localparam logic [7:0] OPC_CMP_ABS = 8'hCD;
   localparam logic [7:0] OPC_CPY_ZP  = 8'hC4;
   localparam logic [7:0] OPC_CPY_ABS = 8'hCC;
   localparam logic [7:0] OPC_DEC_ZP  = 8'hC6;
   localparam logic [7:0] OPC_DEC_ABS = 8'hCE;
   localparam logic [7:0] OPC_DEX     = 8'hCA;
   localparam logic [7:0] OPC_TAX     = 8'hAA;
   localparam logic [7:0] OPC_TXA     = 8'h8A;
   localparam logic [7:0] OPC_TXS     = 8'h9A;
   localparam logic [7:0] OPC_TSX     = 8'hBA;
   localparam logic [7:0] OPC_NOP     = 8'hEA;

   // Decoded word, handed from the address stage to the execute stage
   typedef struct packed {
      logic [3:0]  cls;
      logic [1:0]  src_reg;
      logic [1:0]  dst_reg;
      logic        decr;
      logic        set_nz;
      logic        mem_read;
      logic        mem_write;
      logic        need_x;
      logic        need_y;
      logic [15:0] addr;
      logic [7:0]  imm;
      logic [7:0]  hdata;
   } dec_type;

   // Memory write request from the execute stage
   typedef struct packed {
      logic        en;
      logic [15:0] addr;
      logic [7:0]  data;
   } mem_wr_type;

   // Index registers that the word in the execute stage will change
   typedef struct packed {
      logic wr_x;
      logic wr_y;
   } haz_type;

   // Result word
   typedef struct packed {
      logic       unsup;
      logic [7:0] read_byte;
      logic [2:0] flags;
      logic [7:0] sp;
      logic [7:0] y;
      logic [7:0] x;
      logic [7:0] acc;
   } res_type;

endpackage

`default_nettype wire

### rtl/core/cpu8lsc_decode.sv
// Opcode decode and effective address generation for the address stage.
`timescale 1ns / 1ps
`default_nettype none

module cpu8lsc_decode (
   input  wire logic [1:0]         operation,
   input  wire logic [7:0]         opcode,
   input  wire logic [15:0]        operand,
   input  wire logic [7:0]         host_data,
   input  wire logic [7:0]         x_val,
   input  wire logic [7:0]         y_val,
   output cpu8lsc_pkg::dec_type    dec
);

   logic [3:0] cls;
   logic [2:0] mode;
   logic [1:0] src_reg;
   logic [1:0] dst_reg;
   logic       decr;
   logic       set_nz;
   logic [7:0] zp_x;
   logic [7:0] zp_y;
   logic [15:0] addr;

   // Opcode table
   always_comb begin
      cls     = cpu8lsc_pkg::CLS_UNSUP;
      mode    = cpu8lsc_pkg::AM_NONE;
      src_reg = cpu8lsc_pkg::REG_A;
      dst_reg = cpu8lsc_pkg::REG_A;
      decr    = 1'b0;
      set_nz  = 1'b1;
      case (opcode)
         cpu8lsc_pkg::OPC_LDA_IMM: begin cls = cpu8lsc_pkg::CLS_LOAD; mode = cpu8lsc_pkg::AM_IMM; end
         cpu8lsc_pkg::OPC_LDA_ZP:  begin cls = cpu8lsc_pkg::CLS_LOAD; mode = cpu8lsc_pkg::AM_ZP; end
         cpu8lsc_pkg::OPC_LDA_ZPX: begin cls = cpu8lsc_pkg::CLS_LOAD; mode = cpu8lsc_pkg::AM_ZPX; end
         cpu8lsc_pkg::OPC_LDA_ABS: begin cls = cpu8lsc_pkg::CLS_LOAD; mode = cpu8lsc_pkg::AM_ABS; end
         cpu8lsc_pkg::OPC_LDA_ABX: begin cls = cpu8lsc_pkg::CLS_LOAD; mode = cpu8lsc_pkg::AM_ABX; end
         cpu8lsc_pkg::OPC_LDA_ABY: begin cls = cpu8lsc_pkg::CLS_LOAD; mode = cpu8lsc_pkg::AM_ABY; end
         cpu8lsc_pkg::OPC_LDX_IMM: begin
            cls = cpu8lsc_pkg::CLS_LOAD; mode = cpu8lsc_pkg::AM_IMM; dst_reg = cpu8lsc_pkg::REG_X;
         end
         cpu8lsc_pkg::OPC_LDX_ZP: begin
            cls = cpu8lsc_pkg::CLS_LOAD; mode = cpu8lsc_pkg::AM_ZP; dst_reg = cpu8lsc_pkg::REG_X;
         end
         cpu8lsc_pkg::OPC_LDX_ZPY: begin
            cls = cpu8lsc_pkg::CLS_LOAD; mode = cpu8lsc_pkg::AM_ZPY; dst_reg = cpu8lsc_pkg::REG_X;
         end
         cpu8lsc_pkg::OPC_LDX_ABS: begin
            cls = cpu8lsc_pkg::CLS_LOAD; mode = cpu8lsc_pkg::AM_ABS; dst_reg = cpu8lsc_pkg::REG_X;
         end
         cpu8lsc_pkg::OPC_LDX_ABY: begin
            cls = cpu8lsc_pkg::CLS_LOAD; mode = cpu8lsc_pkg::AM_ABY; dst_reg = cpu8lsc_pkg::REG_X;
         end
         cpu8lsc_pkg::OPC_LDY_IMM: begin
            cls = cpu8lsc_pkg::CLS_LOAD; mode = cpu8lsc_pkg::AM_IMM; dst_reg = cpu8lsc_pkg::REG_Y;
         end
         cpu8lsc_pkg::OPC_LDY_ZP: begin
            cls = cpu8lsc_pkg::CLS_LOAD; mode = cpu8lsc_pkg::AM_ZP; dst_reg = cpu8lsc_pkg::REG_Y;
         end
         cpu8lsc_pkg::OPC_LDY_ZPX: begin
            cls = cpu8lsc_pkg::CLS_LOAD; mode = cpu8lsc_pkg::AM_ZPX; dst_reg = cpu8lsc_pkg::REG_Y;
         end
         cpu8lsc_pkg::OPC_LDY_ABS: begin
            cls = cpu8lsc_pkg::CLS_LOAD; mode = cpu8lsc_pkg::AM_ABS; dst_reg = cpu8lsc_pkg::REG_Y;
         end
         cpu8lsc_pkg::OPC_LDY_ABX: begin
            cls = cpu8lsc_pkg::CLS_LOAD; mode = cpu8lsc_pkg::AM_ABX; dst_reg = cpu8lsc_pkg::REG_Y;
         end
         cpu8lsc_pkg::OPC_STA_ZP:  begin cls = cpu8lsc_pkg::CLS_STORE; mode = cpu8lsc_pkg::AM_ZP; end
         cpu8lsc_pkg::OPC_STA_ZPX: begin cls = cpu8lsc_pkg::CLS_STORE; mode = cpu8lsc_pkg::AM_ZPX; end
         cpu8lsc_pkg::OPC_STA_ABS: begin cls = cpu8lsc_pkg::CLS_STORE; mode = cpu8lsc_pkg::AM_ABS; end
         cpu8lsc_pkg::OPC_STA_ABX: begin cls = cpu8lsc_pkg::CLS_STORE; mode = cpu8lsc_pkg::AM_ABX; end
         cpu8lsc_pkg::OPC_STA_ABY: begin cls = cpu8lsc_pkg::CLS_STORE; mode = cpu8lsc_pkg::AM_ABY; end
         cpu8lsc_pkg::OPC_STX_ZP: begin
            cls = cpu8lsc_pkg::CLS_STORE; mode = cpu8lsc_pkg::AM_ZP; src_reg = cpu8lsc_pkg::REG_X;
         end
         cpu8lsc_pkg::OPC_STX_ZPY: begin
            cls = cpu8lsc_pkg::CLS_STORE; mode = cpu8lsc_pkg::AM_ZPY; src_reg = cpu8lsc_pkg::REG_X;
         end
         cpu8lsc_pkg::OPC_STX_ABS: begin
            cls = cpu8lsc_pkg::CLS_STORE; mode = cpu8lsc_pkg::AM_ABS; src_reg = cpu8lsc_pkg::REG_X;
         end
         cpu8lsc_pkg::OPC_STY_ZP: begin
            cls = cpu8lsc_pkg::CLS_STORE; mode = cpu8lsc_pkg::AM_ZP; src_reg = cpu8lsc_pkg::REG_Y;
         end
         cpu8lsc_pkg::OPC_STY_ZPX: begin
            cls = cpu8lsc_pkg::CLS_STORE; mode = cpu8lsc_pkg::AM_ZPX; src_reg = cpu8lsc_pkg::REG_Y;
         end
         cpu8lsc_pkg::OPC_STY_ABS: begin
            cls = cpu8lsc_pkg::CLS_STORE; mode = cpu8lsc_pkg::AM_ABS; src_reg = cpu8lsc_pkg::REG_Y;
         end
         cpu8lsc_pkg::OPC_CMP_IMM: begin cls = cpu8lsc_pkg::CLS_CMP; mode = cpu8lsc_pkg::AM_IMM; end
         cpu8lsc_pkg::OPC_CMP_ZP:  begin cls = cpu8lsc_pkg::CLS_CMP; mode = cpu8lsc_pkg::AM_ZP; end
         cpu8lsc_pkg::OPC_CMP_ABS: begin cls = cpu8lsc_pkg::CLS_CMP; mode = cpu8lsc_pkg::AM_ABS; end
         cpu8lsc_pkg::OPC_CPY_ZP: begin
            cls = cpu8lsc_pkg::CLS_CMP; mode = cpu8lsc_pkg::AM_ZP; src_reg = cpu8lsc_pkg::REG_Y;
         end
         cpu8lsc_pkg::OPC_CPY_ABS: begin
            cls = cpu8lsc_pkg::CLS_CMP; mode = cpu8lsc_pkg::AM_ABS; src_reg = cpu8lsc_pkg::REG_Y;
         end
         cpu8lsc_pkg::OPC_DEC_ZP:  begin cls = cpu8lsc_pkg::CLS_DEC; mode = cpu8lsc_pkg::AM_ZP; end
         cpu8lsc_pkg::OPC_DEC_ABS: begin cls = cpu8lsc_pkg::CLS_DEC; mode = cpu8lsc_pkg::AM_ABS; end
         cpu8lsc_pkg::OPC_DEX: begin
            cls = cpu8lsc_pkg::CLS_MOVE; decr = 1'b1;
            src_reg = cpu8lsc_pkg::REG_X; dst_reg = cpu8lsc_pkg::REG_X;
         end
         cpu8lsc_pkg::OPC_TAX: begin
            cls = cpu8lsc_pkg::CLS_MOVE; src_reg = cpu8lsc_pkg::REG_A; dst_reg = cpu8lsc_pkg::REG_X;
         end
         cpu8lsc_pkg::OPC_TXA: begin
            cls = cpu8lsc_pkg::CLS_MOVE; src_reg = cpu8lsc_pkg::REG_X; dst_reg = cpu8lsc_pkg::REG_A;
         end
         cpu8lsc_pkg::OPC_TXS: begin
            cls = cpu8lsc_pkg::CLS_MOVE; set_nz = 1'b0;
            src_reg = cpu8lsc_pkg::REG_X; dst_reg = cpu8lsc_pkg::REG_S;
         end
         cpu8lsc_pkg::OPC_TSX: begin
            cls = cpu8lsc_pkg::CLS_MOVE; src_reg = cpu8lsc_pkg::REG_S; dst_reg = cpu8lsc_pkg::REG_X;
         end
         cpu8lsc_pkg::OPC_NOP: begin cls = cpu8lsc_pkg::CLS_NOP; end
         default: begin cls = cpu8lsc_pkg::CLS_UNSUP; end
      endcase
   end

   // Effective address: zero page wraps at 8 bits, absolute at 16 bits
   assign zp_x = operand[7:0] + x_val;
   assign zp_y = operand[7:0] + y_val;

   always_comb begin
      case (mode)
         cpu8lsc_pkg::AM_ZP:  addr = {8'h00, operand[7:0]};
         cpu8lsc_pkg::AM_ZPX: addr = {8'h00, zp_x};
         cpu8lsc_pkg::AM_ZPY: addr = {8'h00, zp_y};
         cpu8lsc_pkg::AM_ABX: addr = operand + {8'h00, x_val};
         cpu8lsc_pkg::AM_ABY: addr = operand + {8'h00, y_val};
         default:             addr = operand;
      endcase
   end

   // Operation selector overrides the opcode for host access and turns an unused selector into a NOP
   always_comb begin
      dec.src_reg   = src_reg;
      dec.dst_reg   = dst_reg;
      dec.decr      = decr;
      dec.set_nz    = set_nz;
      dec.imm       = operand[7:0];
      dec.hdata     = host_data;
      dec.cls       = cls;
      dec.addr      = addr;
      dec.mem_read  = (mode != cpu8lsc_pkg::AM_NONE) && (mode != cpu8lsc_pkg::AM_IMM) &&
                      (cls != cpu8lsc_pkg::CLS_STORE);
      dec.mem_write = (cls == cpu8lsc_pkg::CLS_STORE) || (cls == cpu8lsc_pkg::CLS_DEC);
      dec.need_x    = (mode == cpu8lsc_pkg::AM_ZPX) || (mode == cpu8lsc_pkg::AM_ABX);
      dec.need_y    = (mode == cpu8lsc_pkg::AM_ZPY) || (mode == cpu8lsc_pkg::AM_ABY);
      case (operation)
         cpu8lsc_pkg::OPER_EXEC: begin
         end
         cpu8lsc_pkg::OPER_HWR: begin
            dec.cls       = cpu8lsc_pkg::CLS_HWR;
            dec.addr      = operand;
            dec.mem_read  = 1'b0;
            dec.mem_write = 1'b1;
            dec.need_x    = 1'b0;
            dec.need_y    = 1'b0;
         end
         cpu8lsc_pkg::OPER_HRD: begin
            dec.cls       = cpu8lsc_pkg::CLS_HRD;
            dec.addr      = operand;
            dec.mem_read  = 1'b1;
            dec.mem_write = 1'b0;
            dec.need_x    = 1'b0;
            dec.need_y    = 1'b0;
         end
         default: begin
            dec.cls       = cpu8lsc_pkg::CLS_NOP;
            dec.mem_read  = 1'b0;
            dec.mem_write = 1'b0;
            dec.need_x    = 1'b0;
            dec.need_y    = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

### rtl/core/cpu8lsc_mem.sv
// Byte memory with registered read port and write-to-read forwarding.
`timescale 1ns / 1ps
`default_nettype none

module cpu8lsc_mem #(
   parameter int MEM_BYTES = 65536
) (
   input  wire logic                  clock,
   input  wire logic                  rd_en,
   input  wire logic [15:0]           rd_addr,
   input  wire cpu8lsc_pkg::mem_wr_type wr,
   output logic [7:0]                 rd_data
);

   localparam int AW = $clog2(MEM_BYTES);

   logic [7:0]    byte_mem_ff [MEM_BYTES];
   logic [7:0]    q_ff;
   logic          fwd_ff;
   logic [7:0]    fwd_data_ff;
   logic [AW-1:0] rd_idx;
   logic [AW-1:0] wr_idx;
   logic          fwd_in;

   // Address folds onto the memory size
   assign rd_idx = rd_addr[AW-1:0];
   assign wr_idx = wr.addr[AW-1:0];
   assign fwd_in = wr.en && (wr_idx == rd_idx);

   // Write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         byte_mem_ff[wr_idx] <= wr.data;
      end
   end

   // Read port; a same-cycle write to the same byte is forwarded
   always_ff @(posedge clock) begin
      if (rd_en) begin
         q_ff        <= byte_mem_ff[rd_idx];
         fwd_ff      <= fwd_in;
         fwd_data_ff <= wr.data;
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : q_ff;

`ifndef SYNTHESIS
   a_fwd_same_byte: assert property (@(posedge clock)
      (rd_en && fwd_in) |=> (rd_data == $past(wr.data)))
      else $error("read after same-cycle write returned stale byte");
`endif

endmodule

`default_nettype wire

### rtl/core/cpu8lsc_exec.sv
// Execute stage: register file, flag logic, memory write-back and result register.
`timescale 1ns / 1ps
`default_nettype none

module cpu8lsc_exec (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  take,
   input  wire cpu8lsc_pkg::dec_type  dec,
   input  wire logic [7:0]            rd_data,
   input  wire logic                  rsp_ready,
   output logic                       rsp_valid,
   output cpu8lsc_pkg::res_type       res,
   output logic                       s2_open,
   output logic [7:0]                 x_val,
   output logic [7:0]                 y_val,
   output cpu8lsc_pkg::haz_type       haz,
   output cpu8lsc_pkg::mem_wr_type    wr
);

   logic                 s2_valid_ff;
   cpu8lsc_pkg::dec_type s2_ff;
   logic [7:0]           acc_ff, acc_in;
   logic [7:0]           x_ff, x_in;
   logic [7:0]           y_ff, y_in;
   logic [7:0]           sp_ff, sp_in;
   logic [2:0]           flag_ff, flag_in;
   logic                 rsp_valid_ff;
   cpu8lsc_pkg::res_type rsp_ff;
   logic                 s2_go;
   logic [7:0]           data_op;
   logic [7:0]           src_val;
   logic [7:0]           dec_val;
   logic [7:0]           mv_val;
   logic [7:0]           diff;
   logic [7:0]           nz_val;

   // Stage advance
   assign s2_go   = s2_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign s2_open = !s2_valid_ff || s2_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (take) begin
         s2_valid_ff <= 1'b1;
      end else if (s2_go) begin
         s2_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s2_ff <= dec;
      end
   end

   // Operand selection
   assign data_op = s2_ff.mem_read ? rd_data : s2_ff.imm;

   always_comb begin
      case (s2_ff.src_reg)
         cpu8lsc_pkg::REG_A: src_val = acc_ff;
         cpu8lsc_pkg::REG_X: src_val = x_ff;
         cpu8lsc_pkg::REG_Y: src_val = y_ff;
         default:            src_val = sp_ff;
      endcase
   end

   assign dec_val = rd_data - 8'd1;
   assign mv_val  = s2_ff.decr ? (src_val - 8'd1) : src_val;
   assign diff    = src_val - data_op;

   // Next register state
   always_comb begin
      acc_in  = acc_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      sp_in   = sp_ff;
      flag_in = flag_ff;
      nz_val  = 8'h00;
      case (s2_ff.cls)
         cpu8lsc_pkg::CLS_LOAD: nz_val = data_op;
         cpu8lsc_pkg::CLS_MOVE: nz_val = mv_val;
         cpu8lsc_pkg::CLS_DEC:  nz_val = dec_val;
         default:               nz_val = 8'h00;
      endcase
      case (s2_ff.cls)
         cpu8lsc_pkg::CLS_LOAD, cpu8lsc_pkg::CLS_MOVE: begin
            case (s2_ff.dst_reg)
               cpu8lsc_pkg::REG_A: acc_in = nz_val;
               cpu8lsc_pkg::REG_X: x_in   = nz_val;
               cpu8lsc_pkg::REG_Y: y_in   = nz_val;
               default:            sp_in  = nz_val;
            endcase
            if (s2_ff.set_nz) begin
               flag_in = {nz_val[7], nz_val == 8'h00, flag_ff[cpu8lsc_pkg::FLAG_C]};
            end
         end
         cpu8lsc_pkg::CLS_DEC: begin
            flag_in = {nz_val[7], nz_val == 8'h00, flag_ff[cpu8lsc_pkg::FLAG_C]};
         end
         cpu8lsc_pkg::CLS_CMP: begin
            flag_in = {diff[7], src_val == data_op, src_val >= data_op};
         end
         default: begin
         end
      endcase
   end

   // Architectural registers
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= 8'h00;
         x_ff    <= 8'h00;
         y_ff    <= 8'h00;
         sp_ff   <= 8'h00;
         flag_ff <= 3'b000;
      end else if (s2_go) begin
         acc_ff  <= acc_in;
         x_ff    <= x_in;
         y_ff    <= y_in;
         sp_ff   <= sp_in;
         flag_ff <= flag_in;
      end
   end

   // Memory write-back: stores, DEC and host writes
   always_comb begin
      wr.en   = s2_go && s2_ff.mem_write;
      wr.addr = s2_ff.addr;
      case (s2_ff.cls)
         cpu8lsc_pkg::CLS_DEC: wr.data = dec_val;
         cpu8lsc_pkg::CLS_HWR: wr.data = s2_ff.hdata;
         default:              wr.data = src_val;
      endcase
   end

   // Index registers pending in this stage
   assign haz.wr_x = s2_valid_ff && (s2_ff.dst_reg == cpu8lsc_pkg::REG_X) &&
                     ((s2_ff.cls == cpu8lsc_pkg::CLS_LOAD) || (s2_ff.cls == cpu8lsc_pkg::CLS_MOVE));
   assign haz.wr_y = s2_valid_ff && (s2_ff.dst_reg == cpu8lsc_pkg::REG_Y) &&
                     ((s2_ff.cls == cpu8lsc_pkg::CLS_LOAD) || (s2_ff.cls == cpu8lsc_pkg::CLS_MOVE));
   assign x_val = x_ff;
   assign y_val = y_ff;

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_go) begin
         rsp_ff.acc       <= acc_in;
         rsp_ff.x         <= x_in;
         rsp_ff.y         <= y_in;
         rsp_ff.sp        <= sp_in;
         rsp_ff.flags     <= flag_in;
         rsp_ff.read_byte <= (s2_ff.cls == cpu8lsc_pkg::CLS_HRD) ? rd_data : 8'h00;
         rsp_ff.unsup     <= (s2_ff.cls == cpu8lsc_pkg::CLS_UNSUP);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign res       = rsp_ff;

`ifndef SYNTHESIS
   a_unsup_keeps_state: assert property (@(posedge clock) disable iff (reset)
      (s2_go && (s2_ff.cls == cpu8lsc_pkg::CLS_UNSUP)) |=>
      ($stable(acc_ff) && $stable(x_ff) && $stable(y_ff) && $stable(sp_ff) && $stable(flag_ff)))
      else $error("unsupported opcode changed register state");

   a_sp_only_by_txs: assert property (@(posedge clock) disable iff (reset)
      !(s2_go && (s2_ff.cls == cpu8lsc_pkg::CLS_MOVE) && (s2_ff.dst_reg == cpu8lsc_pkg::REG_S))
      |=> $stable(sp_ff))
      else $error("stack pointer changed outside a transfer to it");

   a_rsp_from_stage: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s2_valid_ff))
      else $error("result appeared with no word in the execute stage");
`endif

endmodule

`default_nettype wire

### rtl/core/cpu8_load_store_compare_unit.sv
// Top level of the 8-bit load/store/compare unit.
`timescale 1ns / 1ps
`default_nettype none

// Executes one decoded 8-bit CPU instruction (loads, stores, compares, DEC,
// DEX, register transfers, NOP) or one host byte read/write per request word
// against an internal byte memory of MEM_BYTES bytes (a power of two; addresses
// fold onto it). Each request word yields exactly one response word holding
// A, X, Y, S, N/Z/C, the host-read byte and an unsupported-opcode flag; an
// unsupported opcode changes nothing. The address stage decodes a request,
// forms the address and issues the memory read; the execute stage then
// computes, writes back to the memory and registers the result. One word is
// accepted per cycle while responses are taken and no index interlock holds;
// a held response stops input once two words are inside. A request whose
// indexed address uses X or Y while the word in the execute stage is writing
// that register waits until that word completes. A write in the execute stage
// to the byte being read is forwarded. Memory contents are undefined until
// written; there is no clearing pass after reset.
module cpu8_load_store_compare_unit #(
   parameter int MEM_BYTES = 65536
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request: tdata = opcode[7:0], operand[23:8], host_data[31:24]
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,
   // request: tuser = operation[1:0]
   input  wire logic [1:0]  req_tuser,
   // response: tdata = acc_value[7:0], x_value[15:8], y_value[23:16],
   // stack_value[31:24], flag_bits[34:32], read_byte[42:35], zero[47:43]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,
   // response: tuser = unsupported[0]
   output logic [0:0]       rsp_tuser
);

   cpu8lsc_pkg::dec_type    dec;
   cpu8lsc_pkg::haz_type    haz;
   cpu8lsc_pkg::mem_wr_type wr;
   cpu8lsc_pkg::res_type    res;
   logic [7:0]              x_val;
   logic [7:0]              y_val;
   logic [7:0]              rd_data;
   logic                    s2_open;
   logic                    hazard;
   logic                    take;

   // Address stage decode
   cpu8lsc_decode u_decode (
      .operation (req_tuser),
      .opcode    (req_tdata[7:0]),
      .operand   (req_tdata[23:8]),
      .host_data (req_tdata[31:24]),
      .x_val     (x_val),
      .y_val     (y_val),
      .dec       (dec)
   );

   // Index interlock and acceptance
   assign hazard     = (dec.need_x && haz.wr_x) || (dec.need_y && haz.wr_y);
   assign req_tready = s2_open && !hazard;
   assign take       = req_tvalid && req_tready;

   // Byte memory
   cpu8lsc_mem #(
      .MEM_BYTES (MEM_BYTES)
   ) u_mem (
      .clock   (clock),
      .rd_en   (take && dec.mem_read),
      .rd_addr (dec.addr),
      .wr      (wr),
      .rd_data (rd_data)
   );

   // Execute stage and result register
   cpu8lsc_exec u_exec (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .dec       (dec),
      .rd_data   (rd_data),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .res       (res),
      .s2_open   (s2_open),
      .x_val     (x_val),
      .y_val     (y_val),
      .haz       (haz),
      .wr        (wr)
   );

   // Response packing
   assign rsp_tdata = {5'b00000, res.read_byte, res.flags, res.sp, res.y, res.x, res.acc};
   assign rsp_tuser = res.unsup;

endmodule

`default_nettype wire
